// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ilir_pkg.sv =====
package ilir_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_POP    = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_GET    = 3'd4,
      CMD_SET    = 3'd5,
      CMD_CLEAR  = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // What every cell does on the current clock edge.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_WRITE,
      OP_SHIFT_UP,
      OP_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  index;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [4:0]  count;
   } rsp_type;

endpackage

// ===== hw/rtl/ilir_cell.sv =====
module ilir_cell #(
   parameter int POS = 0,
   parameter int IW  = 4,
   parameter int EW  = 32
) (
   input  logic                  clock,
   input  ilir_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]         pos,
   input  logic [IW-1:0]         rpos,
   input  logic [EW-1:0]         wr_data,
   input  logic [EW-1:0]         left_data,
   input  logic [EW-1:0]         right_data,
   output logic [EW-1:0]         data,
   output logic [EW-1:0]         rd_term
);

   localparam logic [IW-1:0] MyPos = IW'(POS);

   logic [EW-1:0] data_ff;
   logic [EW-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         ilir_pkg::OP_WRITE: begin
            if (pos == MyPos) data_in = wr_data;
         end
         ilir_pkg::OP_SHIFT_UP: begin
            if (pos == MyPos) begin
               data_in = wr_data;
            end else if (pos < MyPos) begin
               data_in = left_data;
            end
         end
         ilir_pkg::OP_SHIFT_DOWN: begin
            if (pos <= MyPos) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_term = (rpos == MyPos) ? data_ff : '0;

endmodule

// ===== hw/rtl/ilir_ctrl.sv =====
module ilir_ctrl #(
   parameter int DEPTH = 16,
   parameter int IW    = 4,
   parameter int LW    = 5,
   parameter int EW    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ilir_pkg::req_type      req,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ilir_pkg::rsp_type      rsp,
   output ilir_pkg::cell_ctl_type ctl,
   output logic [IW-1:0]          pos,
   output logic [IW-1:0]          rpos,
   output logic [EW-1:0]          wr_data,
   input  logic [EW-1:0]          rd_data
);

   localparam int CW = (LW > 5) ? LW : 5;
   localparam logic [LW-1:0] Full = LW'(DEPTH);

   logic                   accept;
   logic [LW-1:0]          len_ff;
   logic [LW-1:0]          len_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ilir_pkg::rsp_type      rsp_ff;
   ilir_pkg::rsp_type      rsp_in;
   ilir_pkg::cell_op_type  op;
   ilir_pkg::status_type   status;
   logic                   read_ok;
   logic [CW-1:0]          idx_ext;
   logic [CW-1:0]          len_ext;
   logic [CW-1:0]          cnt_ext;
   logic [LW-1:0]          len_dec;
   logic [63:0]            val_wide;
   logic [63:0]            rd_wide;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign idx_ext   = CW'(req.index);
   assign len_ext   = CW'(len_ff);
   assign len_dec   = len_ff - 1'b1;
   assign val_wide  = 64'(req.value);
   assign wr_data   = val_wide[EW-1:0];

   always_comb begin
      op      = ilir_pkg::OP_HOLD;
      status  = ilir_pkg::ST_OK;
      read_ok = 1'b0;
      len_in  = len_ff;
      pos     = idx_ext[IW-1:0];
      rpos    = idx_ext[IW-1:0];
      case (ilir_pkg::cmd_type'(req.command))
         ilir_pkg::CMD_PUSH: begin
            pos = len_ff[IW-1:0];
            if (len_ff == Full) begin
               status = ilir_pkg::ST_FULL;
            end else begin
               op     = ilir_pkg::OP_WRITE;
               len_in = len_ff + 1'b1;
            end
         end
         ilir_pkg::CMD_INSERT: begin
            // The range check takes priority over the full check.
            if (idx_ext > len_ext) begin
               status = ilir_pkg::ST_RANGE;
            end else if (len_ff == Full) begin
               status = ilir_pkg::ST_FULL;
            end else begin
               op     = ilir_pkg::OP_SHIFT_UP;
               len_in = len_ff + 1'b1;
            end
         end
         ilir_pkg::CMD_POP: begin
            rpos = len_dec[IW-1:0];
            if (len_ff == '0) begin
               status = ilir_pkg::ST_EMPTY;
            end else begin
               read_ok = 1'b1;
               len_in  = len_dec;
            end
         end
         ilir_pkg::CMD_REMOVE: begin
            if (idx_ext >= len_ext) begin
               status = ilir_pkg::ST_RANGE;
            end else begin
               op     = ilir_pkg::OP_SHIFT_DOWN;
               len_in = len_dec;
            end
         end
         ilir_pkg::CMD_GET: begin
            if (idx_ext >= len_ext) begin
               status = ilir_pkg::ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         ilir_pkg::CMD_SET: begin
            if (idx_ext >= len_ext) begin
               status = ilir_pkg::ST_RANGE;
            end else begin
               op = ilir_pkg::OP_WRITE;
            end
         end
         ilir_pkg::CMD_CLEAR: begin
            if (len_ff == '0) begin
               status = ilir_pkg::ST_EMPTY;
            end else begin
               len_in = '0;
            end
         end
         default: begin
            status = ilir_pkg::ST_OK;
         end
      endcase
   end

   // The cells only move on an accepted item.
   assign ctl.op = accept ? op : ilir_pkg::OP_HOLD;

   assign rd_wide = 64'(rd_data);
   assign cnt_ext = CW'(len_in);

   always_comb begin
      rsp_in.status     = status;
      rsp_in.read_value = read_ok ? rd_wide[31:0] : 32'd0;
      rsp_in.count      = cnt_ext[4:0];
      rsp_valid_in      = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) len_ff <= len_in;
      end
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// Channel   Direction  Payload              Handshake
// req_      in         ilir_pkg::req_type   req_valid / req_stall
// rsp_      out        ilir_pkg::rsp_type   rsp_valid / rsp_stall
//
// For every command, a row of DEPTH cells shifts, writes or
// holds on the edge that accepts the item, so insert and remove finish at
// once. The result is registered and appears on the next cycle.
// Reset clears the element count and rsp_valid; cell contents and rsp
// stay unknown until written. req_stall is high only while a result is
// waiting and rsp_stall is high, so one item per cycle flows otherwise.
module indexed_list_insert_remove #(
   parameter int DEPTH        = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ilir_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ilir_pkg::rsp_type rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int EW = ELEMENT_BITS;

   ilir_pkg::cell_ctl_type ctl;
   logic [IW-1:0]          pos;
   logic [IW-1:0]          rpos;
   logic [EW-1:0]          wr_data;
   logic [EW-1:0]          rd_data;
   logic [EW-1:0]          cell_data [DEPTH];
   logic [EW-1:0]          rd_terms  [DEPTH];

   ilir_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .LW    (LW),
      .EW    (EW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .ctl       (ctl),
      .pos       (pos),
      .rpos      (rpos),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [EW-1:0] left_data;
      logic [EW-1:0] right_data;

      // The ends of the row feed back their own contents.
      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ilir_cell #(
         .POS (i),
         .IW  (IW),
         .EW  (EW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (pos),
         .rpos       (rpos),
         .wr_data    (wr_data),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_term    (rd_terms[i])
      );
   end

   // At most one cell, the one at rpos, drives a non-zero term, so an OR selects it.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_data = rd_data | rd_terms[i];
      end
   end

endmodule

// ===== hw/rtl/ilir_checker.sv =====
`include "assert_macros.svh"

module ilir_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ilir_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ilir_pkg::rsp_type rsp
);

   logic req_accept;
   logic no_read_cmd;

   assign req_accept  = !reset && req_valid && !req_stall;
   assign no_read_cmd = (req.command == ilir_pkg::CMD_PUSH)
                     || (req.command == ilir_pkg::CMD_INSERT)
                     || (req.command == ilir_pkg::CMD_REMOVE)
                     || (req.command == ilir_pkg::CMD_SET)
                     || (req.command == ilir_pkg::CMD_CLEAR);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp), "stalled result changed")
   `ASSERT_NEXT(a_one_result, clock, reset, req_accept, rsp_valid,
                "accepted item gave no result")
   `ASSERT_NEXT(a_clear_empties, clock, reset,
                req_accept && (req.command == ilir_pkg::CMD_CLEAR),
                (rsp.status != ilir_pkg::ST_OK) || (rsp.count == 5'd0),
                "successful clear left elements")
   `ASSERT_NEXT(a_no_read_data, clock, reset, req_accept && no_read_cmd,
                rsp.read_value == 32'd0, "read data on a non-reading command")

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
